/* hdl/analog_report_qualifier_core_defines.svh */
// ---------------------------------------------------------------------------
// Analog report qualifier assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ANALOG_REPORT_QUALIFIER_CORE_DEFINES_SVH
`define ANALOG_REPORT_QUALIFIER_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define ARQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ARQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/arq_pkg.sv */
// ---------------------------------------------------------------------------
// Analog report qualifier package
// Widths, register indexes, mode codes and reset values of the qualifier.
// ---------------------------------------------------------------------------
package arq_pkg;

  localparam int unsigned SampleW  = 10;
  localparam int unsigned ThreshW  = 10;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned GainW    = 16;
  localparam int unsigned ScaleW   = 5;
  localparam int unsigned ChanW    = 2;
  localparam int unsigned VoltW    = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  // Count added to the period counter on every measure tick.
  localparam logic [PeriodW-1:0] PollStep = PeriodW'(100);

  // Shift offset subtracted from the gain scale.
  localparam logic [ScaleW-1:0] ScaleBias = ScaleW'(6);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegLowThresh  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHighThresh = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPeriod     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMode       = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGain       = 3'd4;
  localparam logic [CfgIdxW-1:0] RegScale      = 3'd5;
  localparam logic [CfgIdxW-1:0] RegChannel    = 3'd6;

  // Operating modes; the remaining code behaves as disabled.
  localparam logic [ModeW-1:0] ModeMeasure  = 2'd0;
  localparam logic [ModeW-1:0] ModeDigital  = 2'd1;
  localparam logic [ModeW-1:0] ModeDisabled = 2'd2;

  // Result kinds.
  localparam logic KindVoltage = 1'b0;
  localparam logic KindPin     = 1'b1;

  // Register reset values.
  localparam logic [ThreshW-1:0] LowThreshRst  = ThreshW'(50);
  localparam logic [ThreshW-1:0] HighThreshRst = ThreshW'(100);
  localparam logic [PeriodW-1:0] PeriodRst     = PeriodW'(5000);
  localparam logic [GainW-1:0]   GainRst       = GainW'(1);
  localparam logic [ScaleW-1:0]  ScaleRst      = ScaleW'(10);

endpackage

/* hdl/analog_report_qualifier_core.sv */
// ---------------------------------------------------------------------------
// Analog report qualifier core
// Send-on-delta voltage reporter and hysteresis pin comparator for one channel.
// ---------------------------------------------------------------------------
// One converter sample enters per word on the slave stream and yields zero or
// one report word on the master stream. Each sample is captured in an input
// register and qualified by a single pass of logic (a 10x16 multiply, a
// shift, a difference compare and the period count) once the output register
// is free or being read; this pass writes the output register and the channel
// state together. A new sample is taken every cycle; the only thing that stops
// intake is an unread report in the output register, which offers report words
// on the master stream. Measure mode reports when the period count plus the
// poll step reaches the period or the sample moved by more than the low
// threshold; digital mode reports only pin transitions; the disabled mode and
// the remaining code drop samples. Configuration must be written only while
// the core is idle; the core itself does not enforce this.
module analog_report_qualifier_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [arq_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [arq_pkg::CfgDataW-1:0]  cfg_data_i,
  // Sample stream. tdata: sample [9:0], zeros above.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [arq_pkg::InDataW-1:0]   s_axis_tdata_i,
  // Report stream. tdata: channel [1:0], scaled_voltage [17:2], pin_high [18],
  // zeros above. tuser: report_kind [0].
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [arq_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output logic                          m_axis_tuser_o
);
  import arq_pkg::*;

  `include "analog_report_qualifier_core_defines.svh"

  // Configuration registers.
  logic [ThreshW-1:0] low_thresh_q, high_thresh_q;
  logic [PeriodW-1:0] period_q;
  logic [ModeW-1:0]   mode_q;
  logic [GainW-1:0]   gain_q;
  logic [ScaleW-1:0]  scale_q;
  logic [ChanW-1:0]   chan_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thresh_q  <= LowThreshRst;
      high_thresh_q <= HighThreshRst;
      period_q      <= PeriodRst;
      mode_q        <= ModeMeasure;
      gain_q        <= GainRst;
      scale_q       <= ScaleRst;
      chan_cfg_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegLowThresh:  low_thresh_q  <= cfg_data_i[ThreshW-1:0];
        RegHighThresh: high_thresh_q <= cfg_data_i[ThreshW-1:0];
        RegPeriod:     period_q      <= cfg_data_i[PeriodW-1:0];
        RegMode:       mode_q        <= cfg_data_i[ModeW-1:0];
        RegGain:       gain_q        <= cfg_data_i[GainW-1:0];
        RegScale:      scale_q       <= cfg_data_i[ScaleW-1:0];
        RegChannel:    chan_cfg_q    <= cfg_data_i[ChanW-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic               in_valid_q;
  logic [SampleW-1:0] sample_q;
  logic               advance;
  logic               out_valid_q;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      sample_q <= s_axis_tdata_i[SampleW-1:0];
    end
  end

  // Qualification logic.
  logic [PeriodW-1:0] period_cnt_q, period_cnt_d;
  logic [SampleW-1:0] last_rep_q, last_rep_d;
  logic               pin_level_q, pin_level_d;

  logic [SampleW-1:0] diff;
  logic [PeriodW-1:0] cnt_inc;
  logic [VoltW-1:0]   prod;
  logic [ScaleW-1:0]  shamt;
  logic [VoltW-1:0]   volts;
  logic               meas_fire, rise, fall, fire;
  logic               kind_d, pin_d;
  logic [VoltW-1:0]   volts_d;

  always_comb begin
    diff      = (sample_q > last_rep_q) ? (sample_q - last_rep_q) : (last_rep_q - sample_q);
    cnt_inc   = period_cnt_q + PollStep;
    meas_fire = (cnt_inc >= period_q) || (diff > low_thresh_q);
    prod      = VoltW'(sample_q * gain_q);
    shamt     = (scale_q >= ScaleBias) ? (scale_q - ScaleBias) : '0;
    // A shift of the full width or more leaves nothing of the product.
    volts     = (shamt >= ScaleW'(VoltW)) ? '0 : (prod >> shamt);
    rise      = !pin_level_q && (sample_q > high_thresh_q);
    fall      = pin_level_q && (sample_q < low_thresh_q);

    period_cnt_d = period_cnt_q;
    last_rep_d   = last_rep_q;
    pin_level_d  = pin_level_q;
    fire         = 1'b0;
    kind_d       = KindVoltage;
    volts_d      = '0;
    pin_d        = 1'b0;

    case (mode_q)
      ModeMeasure: begin
        fire = meas_fire;
        if (meas_fire) begin
          period_cnt_d = '0;
          last_rep_d   = sample_q;
          volts_d      = volts;
        end else begin
          period_cnt_d = cnt_inc;
        end
      end
      ModeDigital: begin
        fire   = rise || fall;
        kind_d = KindPin;
        pin_d  = rise;
        if (rise || fall) begin
          pin_level_d = rise;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_cnt_q <= '0;
      last_rep_q   <= '0;
      pin_level_q  <= 1'b0;
    end else if (advance) begin
      period_cnt_q <= period_cnt_d;
      last_rep_q   <= last_rep_d;
      pin_level_q  <= pin_level_d;
    end
  end

  // Output register.
  logic               kind_q, pin_q;
  logic [ChanW-1:0]   chan_q;
  logic [VoltW-1:0]   volts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q && !m_axis_tready_i) || (advance && fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && fire) begin
      kind_q  <= kind_d;
      chan_q  <= chan_cfg_q;
      volts_q <= volts_d;
      pin_q   <= pin_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = kind_q;
  assign m_axis_tdata_o  = {(OutDataW - ChanW - VoltW - 1)'(0), pin_q, volts_q, chan_q};

  // Assertions.
  `ARQ_ASSERT(a_pin_only_digital, !(out_valid_q && kind_q == KindPin) || mode_q == ModeDigital,
    "pin status report outside digital mode")
  `ARQ_ASSERT(a_pin_tracks_level, !(out_valid_q && kind_q == KindPin) || pin_q == pin_level_q,
    "pin status report disagrees with pin level")
  `ARQ_ASSERT(a_voltage_pin_low, !(out_valid_q && kind_q == KindVoltage) || !pin_q,
    "voltage report carries a pin level")
  `ARQ_ASSERT_NEXT(a_report_clears_count, advance && fire && mode_q == ModeMeasure,
    period_cnt_q == '0, "period counter not cleared by a voltage report")
  `ARQ_ASSERT(a_no_overwrite, !(out_valid_q && !m_axis_tready_i) || !advance,
    "sample qualified while a report is stalled")

endmodule
